>>> rtl/bmpd_pkg.sv
package bmpd_pkg;

  // Fixed BMP header length in bytes
  localparam int HEADER_BYTES  = 54;
  // Width of the saturating byte position counter
  localparam int POSITION_BITS = 36;
  // Width of the required file size (offset + height * padded line)
  localparam int NEED_BITS     = 36;
  // Common width for the size compare
  localparam int CMP_BITS      = (POSITION_BITS > NEED_BITS) ? POSITION_BITS : NEED_BITS;

  typedef logic [POSITION_BITS-1:0] pos_t;

  localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};

  // Header byte positions
  localparam pos_t POS_MARK0  = pos_t'(0);
  localparam pos_t POS_MARK1  = pos_t'(1);
  localparam pos_t POS_OFS_LO = pos_t'(10);
  localparam pos_t POS_OFS_HI = pos_t'(11);
  localparam pos_t POS_WID_LO = pos_t'(18);
  localparam pos_t POS_WID_HI = pos_t'(19);
  localparam pos_t POS_HGT_LO = pos_t'(22);
  localparam pos_t POS_HGT_HI = pos_t'(23);
  localparam pos_t POS_DEPTH  = pos_t'(28);
  localparam pos_t POS_HDR    = pos_t'(HEADER_BYTES);

  localparam logic [7:0] CHAR_B   = 8'h42;
  localparam logic [7:0] CHAR_M   = 8'h4D;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Bytes per pixel codes
  localparam logic [2:0] BPP_NONE = 3'd0;
  localparam logic [2:0] BPP_3    = 3'd3;
  localparam logic [2:0] BPP_4    = 3'd4;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_NOT_BMP   = 3'd2,
    STATUS_BAD_DEPTH = 3'd3,
    STATUS_TOO_SMALL = 3'd4,
    STATUS_OFFSET    = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // Input word
  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    kind_t       kind;
    logic [15:0] column;
    logic [15:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    status_t     status;
    logic        final_res;
  } out_word_t;

  // Header fields handed from the parser to the size unit
  typedef struct packed {
    logic [15:0] pixel_start;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  bytes_per_pixel;
  } hdr_t;

  // Results of one accepted byte, handed to the result queue
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } push_t;

endpackage

>>> rtl/bmp_stream_to_rgba_decoder_top.sv
// Channel   | Handshake                 | Word
// ----------+---------------------------+-------------------------------------
// file in   | byte_valid / byte_stall   | byte_word (file_byte, last_byte)
// result    | res_valid / res_stall     | res_word (pixel or final status)
//
// One file byte is taken every clock while the result queue has room for two words.
// A pixel word is written into the queue when its last byte is taken; on the final byte a
// status word follows it. The queue holds four words and decouples the stall
// of the result side; the byte side is stalled while it holds three or more.
// Synchronous reset clears the parser and empties the queue; the final byte of
// a file returns the parser to its reset state for the next file.
module bmp_stream_to_rgba_decoder_top
  import bmpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_word_t  byte_word,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res_word
);

  logic                 accept;
  logic                 full;
  hdr_t                 hdr;
  push_t                push;
  logic [NEED_BITS-1:0] need;

  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  // Header parse, pixel assembly and status
  bmpd_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (byte_word),
    .need   (need),
    .hdr    (hdr),
    .push   (push)
  );

  // Minimum file size from the header
  bmpd_size u_size (
    .clk  (clk),
    .hdr  (hdr),
    .need (need)
  );

  // Result queue
  bmpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule

>>> rtl/bmpd_size.sv
module bmpd_size
  import bmpd_pkg::*;
(
  input  logic                 clk,
  input  hdr_t                 hdr,
  output logic [NEED_BITS-1:0] need
);

  logic [17:0]           line_raw;
  logic [18:0]           line_pad;
  logic [18:0]           line;
  logic [34:0]           area;

  // Bytes per line: width * 3 or width * 4, rounded up to a multiple of 4
  always_comb begin
    if (hdr.bytes_per_pixel == BPP_4) begin
      line_raw = {hdr.image_width, 2'b00};
    end else begin
      line_raw = {1'b0, hdr.image_width, 1'b0} + {2'b00, hdr.image_width};
    end
    line_pad = ({1'b0, line_raw} + 19'd3) & ~19'd3;
  end

  // Three registered steps; header fields settle long before byte 53
  always_ff @(posedge clk) begin
    line <= line_pad;
    area <= line * hdr.image_height;
    need <= NEED_BITS'(area) + NEED_BITS'(hdr.pixel_start);
  end

endmodule

>>> rtl/bmpd_parse.sv
module bmpd_parse
  import bmpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  in_word_t             word,
  input  logic [NEED_BITS-1:0] need,
  output hdr_t                 hdr,
  output push_t                push
);

  pos_t        byte_position, byte_position_next;
  logic        marker_ok, marker_ok_next;
  logic [15:0] pixel_start, pixel_start_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [2:0]  bytes_per_pixel, bytes_per_pixel_next;
  logic [15:0] column_count, column_count_next;
  logic [16:0] rows_done, rows_done_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [1:0]  pad_left, pad_left_next;
  logic [7:0]  held_blue, held_blue_next;
  logic [7:0]  held_green, held_green_next;
  logic [7:0]  held_red, held_red_next;

  logic        in_header;
  logic        in_pixels;
  logic        pix_done;
  logic [16:0] column_inc;
  logic [1:0]  pad;
  logic [7:0]  b;
  out_word_t   pix_word;
  out_word_t   stat_word;
  status_t     status;

  assign hdr = '{pixel_start:     pixel_start,
                 image_width:     image_width,
                 image_height:    image_height,
                 bytes_per_pixel: bytes_per_pixel};

  assign b = word.file_byte;

  // Byte decode and counter updates
  always_comb begin
    byte_position_next   = (byte_position != POS_MAX) ? byte_position + pos_t'(1) : POS_MAX;
    marker_ok_next       = marker_ok;
    pixel_start_next     = pixel_start;
    image_width_next     = image_width;
    image_height_next    = image_height;
    bytes_per_pixel_next = bytes_per_pixel;
    column_count_next    = column_count;
    rows_done_next       = rows_done;
    byte_in_pixel_next   = byte_in_pixel;
    pad_left_next        = pad_left;
    held_blue_next       = held_blue;
    held_green_next      = held_green;
    held_red_next        = held_red;
    pix_done             = 1'b0;
    column_inc           = {1'b0, column_count} + 17'd1;
    pad                  = (bytes_per_pixel == BPP_3) ? image_width[1:0] : 2'd0;

    in_header = byte_position < POS_HDR;
    in_pixels = !in_header
             && (CMP_BITS'(byte_position) >= CMP_BITS'(pixel_start))
             && (bytes_per_pixel != BPP_NONE) && (image_width != 16'd0)
             && (rows_done < {1'b0, image_height});

    if (in_header) begin
      if ((byte_position == POS_MARK0 && b != CHAR_B) ||
          (byte_position == POS_MARK1 && b != CHAR_M)) begin
        marker_ok_next = 1'b0;
      end
      if (byte_position == POS_OFS_LO) pixel_start_next[7:0]   = b;
      if (byte_position == POS_OFS_HI) pixel_start_next[15:8]  = b;
      if (byte_position == POS_WID_LO) image_width_next[7:0]   = b;
      if (byte_position == POS_WID_HI) image_width_next[15:8]  = b;
      if (byte_position == POS_HGT_LO) image_height_next[7:0]  = b;
      if (byte_position == POS_HGT_HI) image_height_next[15:8] = b;
      if (byte_position == POS_DEPTH) begin
        bytes_per_pixel_next = (b == DEPTH_24) ? BPP_3 : ((b == DEPTH_32) ? BPP_4 : BPP_NONE);
      end
    end else if (in_pixels) begin
      if (pad_left != 2'd0) begin
        // skipping row padding
        pad_left_next = pad_left - 2'd1;
        if (pad_left == 2'd1) rows_done_next = rows_done + 17'd1;
      end else begin
        case (byte_in_pixel)
          2'd0:    held_blue_next  = b;
          2'd1:    held_green_next = b;
          2'd2:    held_red_next   = b;
          default: ;
        endcase
        pix_done = ({1'b0, byte_in_pixel} + 3'd1) >= bytes_per_pixel;
        byte_in_pixel_next = pix_done ? 2'd0 : byte_in_pixel + 2'd1;
        if (pix_done) begin
          if (column_inc >= {1'b0, image_width}) begin
            column_count_next = 16'd0;
            pad_left_next     = pad;
            if (pad == 2'd0) rows_done_next = rows_done + 17'd1;
          end else begin
            column_count_next = column_inc[15:0];
          end
        end
      end
    end
  end

  // Final status, first failing check wins
  always_comb begin
    if (byte_position_next < POS_HDR) begin
      status = STATUS_SHORT;
    end else if (!marker_ok) begin
      status = STATUS_NOT_BMP;
    end else if (bytes_per_pixel == BPP_NONE) begin
      status = STATUS_BAD_DEPTH;
    end else if (CMP_BITS'(byte_position_next) < CMP_BITS'(need)) begin
      status = STATUS_TOO_SMALL;
    end else if (pixel_start < 16'(HEADER_BYTES)) begin
      status = STATUS_OFFSET;
    end else begin
      status = STATUS_OK;
    end
  end

  // Result words
  always_comb begin
    pix_word = '{kind:      KIND_PIXEL,
                 column:    column_count,
                 row:       image_height - 16'd1 - rows_done[15:0],
                 red:       held_red_next,
                 green:     held_green_next,
                 blue:      held_blue_next,
                 alpha:     ALPHA_OPAQUE,
                 status:    STATUS_OK,
                 final_res: 1'b0};
    stat_word = '{kind:      KIND_STATUS,
                  column:    16'd0,
                  row:       16'd0,
                  red:       8'd0,
                  green:     8'd0,
                  blue:      8'd0,
                  alpha:     8'd0,
                  status:    status,
                  final_res: 1'b1};
    push.first  = pix_done ? pix_word : stat_word;
    push.second = stat_word;
    push.count  = accept ? ({1'b0, pix_done} + {1'b0, word.last_byte}) : 2'd0;
  end

  // State registers; the last byte of a file returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (accept && word.last_byte)) begin
      byte_position   <= '0;
      marker_ok       <= 1'b1;
      pixel_start     <= '0;
      image_width     <= '0;
      image_height    <= '0;
      bytes_per_pixel <= BPP_NONE;
      column_count    <= '0;
      rows_done       <= '0;
      byte_in_pixel   <= '0;
      pad_left        <= '0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      marker_ok       <= marker_ok_next;
      pixel_start     <= pixel_start_next;
      image_width     <= image_width_next;
      image_height    <= image_height_next;
      bytes_per_pixel <= bytes_per_pixel_next;
      column_count    <= column_count_next;
      rows_done       <= rows_done_next;
      byte_in_pixel   <= byte_in_pixel_next;
      pad_left        <= pad_left_next;
    end
  end

  // Held colour bytes, always written before they are used
  always_ff @(posedge clk) begin
    if (accept) begin
      held_blue  <= held_blue_next;
      held_green <= held_green_next;
      held_red   <= held_red_next;
    end
  end

endmodule

>>> rtl/bmpd_queue.sv
module bmpd_queue
  import bmpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      full,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res_word
);

  out_word_t  mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  // Room for two words is needed before a byte is taken
  assign full      = count > 3'd2;
  assign res_valid = count != 3'd0;
  assign res_word  = mem[rd_ptr];
  assign pop       = res_valid && !res_stall;

  assign count_next = count + {1'b0, push.count} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  // Word store
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr + 2'd1] <= push.second;
  end

endmodule
